// ----- src/bandwidth_share_negotiator_unit_assert.svh -----
// Assertion macros for the bandwidth share negotiator checker.
// Depends on nothing; included by the checker file.
`ifndef BANDWIDTH_SHARE_NEGOTIATOR_UNIT_ASSERT_SVH
`define BANDWIDTH_SHARE_NEGOTIATOR_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define BSN_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bsn checker: same-cycle property failed");

// Next-cycle implication, disabled while reset is held.
`define BSN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bsn checker: next-cycle property failed");

`endif

// ----- src/bsn_pkg.sv -----
// Shared types and constants for the bandwidth share negotiator.
// No dependencies; used by the top level and its checker.
package bsn_pkg;

    localparam int CFG_DATA_W  = 32;
    localparam int CFG_INDEX_W = 2;

    // register indexes on the config port
    localparam logic [CFG_INDEX_W-1:0] CFG_SAT_UPPER    = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SAT_LOWER    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SETTLE_LIMIT = 2'd2;

    localparam logic [23:0] SAT_UPPER_RST    = 24'd4096;
    localparam logic [23:0] SAT_LOWER_RST    = 24'd1024;
    localparam logic [31:0] SETTLE_LIMIT_RST = 32'd1000;

    localparam logic [1:0] LEVEL_MAX   = 2'd2;
    localparam logic [1:0] LEVEL_RST   = 2'd1;
    localparam logic [1:0] BURST_NONE  = 2'd0;
    localparam logic [1:0] BURST_GRANT = 2'd3;

    localparam logic [4:0] GAIN_DB_L0 = 5'd15;
    localparam logic [4:0] GAIN_DB_L1 = 5'd18;
    localparam logic [4:0] GAIN_DB_L2 = 5'd21;

    typedef struct packed {
        logic [23:0] queue_depth;
        logic [15:0] ticks_passed;
        logic        frame_received;
        logic        control_ok;
        logic        frame_is_control;
        logic [1:0]  peer_request;
    } t_in_req;

    typedef struct packed {
        logic [1:0] level;
        logic [1:0] advertised_level;
        logic       advert_written;
        logic [1:0] control_burst;
        logic       level_applied;
        logic [1:0] tx_alloc_select;
        logic [1:0] rx_alloc_select;
        logic [4:0] gain_db;
        logic       is_saturated;
        logic       request_pending;
    } t_out_req;

endpackage

// ----- src/bandwidth_share_negotiator_unit.sv -----
// Bandwidth share negotiator, top level.
// Depends on bsn_pkg for request types, register indexes and constants.
//
// Takes one tick request per cycle while input ready is high and returns exactly
// one result request per tick. A request is captured in an input register,
// processed by the compare and flag logic against the negotiation state, and
// lands in an output register once that register is free or draining.
// Throughput is one request per cycle while the output is not stalled. While a
// result waits downstream the block still takes one more request into its
// input register, then holds input ready low until the result leaves.
// Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect at the
// next edge; indexes beyond the register list are dropped. Write them only
// when the block holds no request in flight.
module bandwidth_share_negotiator_unit (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    // tick requests
    input  logic                                 i_in_valid,
    output logic                                 o_in_ready,
    input  bsn_pkg::t_in_req                     i_in,
    // results
    output logic                                 o_out_valid,
    input  logic                                 i_out_ready,
    output bsn_pkg::t_out_req                    o_out,
    // config write port
    input  logic                                 i_cfg_we,
    input  logic [bsn_pkg::CFG_INDEX_W-1:0]      i_cfg_index,
    input  logic [bsn_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    // config registers
    logic [23:0] r_sat_upper;
    logic [23:0] r_sat_lower;
    logic [31:0] r_settle_limit;

    // negotiation state
    logic        r_saturated,   n_saturated;
    logic        r_asking,      n_asking;
    logic [1:0]  r_own_level,   n_own_level;
    logic [1:0]  r_asked_level, n_asked_level;
    logic [1:0]  r_last_peer,   n_last_peer;
    logic [31:0] r_settle,      n_settle;

    // pipeline
    logic              r_in_valid;
    bsn_pkg::t_in_req  r_in;
    logic              r_out_valid;
    bsn_pkg::t_out_req r_out, n_out;

    logic        advance;
    logic [32:0] settle_sum;
    logic        wrote;
    logic        applied;
    logic [1:0]  burst;

    // input register moves on when the output register is free or draining
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    assign settle_sum = {1'b0, r_settle} + {17'd0, r_in.ticks_passed};

    always_comb begin
        // settle counter saturates at all ones
        n_settle      = settle_sum[32] ? '1 : settle_sum[31:0];
        n_saturated   = r_saturated;
        n_asking      = r_asking;
        n_own_level   = r_own_level;
        n_asked_level = r_asked_level;
        n_last_peer   = r_last_peer;
        wrote         = 1'b0;
        applied       = 1'b0;
        burst         = bsn_pkg::BURST_NONE;

        // hysteresis
        if (!r_saturated && (r_in.queue_depth > r_sat_upper)) begin
            n_saturated = 1'b1;
        end else if (r_saturated && (r_in.queue_depth < r_sat_lower)) begin
            n_saturated = 1'b0;
        end

        // ask for one level more
        if (n_saturated && (r_own_level < bsn_pkg::LEVEL_MAX) && !r_asking
                && (n_settle > r_settle_limit)) begin
            n_asking      = 1'b1;
            n_asked_level = r_own_level + 2'd1;
            n_settle      = '0;
            wrote         = 1'b1;
        end

        // withdraw once saturation clears
        if (!n_saturated && n_asking) begin
            n_asking      = 1'b0;
            n_asked_level = r_own_level;
            wrote         = 1'b1;
        end

        // peer control info: grant by stepping down, never below level zero
        if (r_in.frame_received && r_in.control_ok) begin
            n_last_peer = r_in.peer_request;
            if (({1'b0, r_in.peer_request} + {1'b0, r_own_level} > 3'd2)
                    && (r_own_level != 2'd0)
                    && (!n_saturated || (r_own_level == bsn_pkg::LEVEL_MAX))) begin
                n_own_level = r_own_level - 2'd1;
                if (n_asked_level != 2'd0) begin
                    n_asked_level = n_asked_level - 2'd1;
                end
                wrote   = 1'b1;
                burst   = bsn_pkg::BURST_GRANT;
                applied = 1'b1;
            end
        end

        // adopt when the peer answers with the complement (stored peer value)
        if (r_in.frame_is_control && n_asking
                && ({1'b0, n_last_peer} + {1'b0, n_asked_level} == 3'd2)) begin
            n_asking    = 1'b0;
            n_own_level = n_asked_level;
            applied     = 1'b1;
        end

        n_out.level            = n_own_level;
        n_out.advertised_level = n_asked_level;
        n_out.advert_written   = wrote;
        n_out.control_burst    = burst;
        n_out.level_applied    = applied;
        n_out.tx_alloc_select  = n_own_level;
        n_out.rx_alloc_select  = bsn_pkg::LEVEL_MAX - n_own_level;
        n_out.is_saturated     = n_saturated;
        n_out.request_pending  = n_asking;
        case (n_own_level)
            2'd0:    n_out.gain_db = bsn_pkg::GAIN_DB_L0;
            2'd1:    n_out.gain_db = bsn_pkg::GAIN_DB_L1;
            default: n_out.gain_db = bsn_pkg::GAIN_DB_L2;
        endcase
    end

    // control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat_upper    <= bsn_pkg::SAT_UPPER_RST;
            r_sat_lower    <= bsn_pkg::SAT_LOWER_RST;
            r_settle_limit <= bsn_pkg::SETTLE_LIMIT_RST;
            r_saturated    <= 1'b0;
            r_asking       <= 1'b0;
            r_own_level    <= bsn_pkg::LEVEL_RST;
            r_asked_level  <= bsn_pkg::LEVEL_RST;
            r_last_peer    <= 2'd0;
            r_settle       <= '0;
            r_in_valid     <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    bsn_pkg::CFG_SAT_UPPER:    r_sat_upper    <= i_cfg_data[23:0];
                    bsn_pkg::CFG_SAT_LOWER:    r_sat_lower    <= i_cfg_data[23:0];
                    bsn_pkg::CFG_SETTLE_LIMIT: r_settle_limit <= i_cfg_data;
                    default: ;
                endcase
            end

            if (o_in_ready) begin
                r_in_valid <= i_in_valid;
            end

            if (advance) begin
                r_saturated   <= n_saturated;
                r_asking      <= n_asking;
                r_own_level   <= n_own_level;
                r_asked_level <= n_asked_level;
                r_last_peer   <= n_last_peer;
                r_settle      <= n_settle;
                r_out_valid   <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in <= i_in;
        end
        if (advance) begin
            r_out <= n_out;
        end
    end

endmodule

// ----- src/bsn_checker.sv -----
// Port-level checker for the bandwidth share negotiator, bound to the top.
// Depends on bsn_pkg and bandwidth_share_negotiator_unit_assert.svh.
`include "bandwidth_share_negotiator_unit_assert.svh"

module bsn_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input bsn_pkg::t_out_req o_out
);

    logic out_stall;
    logic in_open;
    logic ask_open;
    logic burst_seen;
    logic burst_ok;
    logic gain_ok;
    logic level_ok;

    assign out_stall  = o_out_valid && !i_out_ready;
    assign in_open    = i_in_valid && !o_out_valid;
    assign ask_open   = o_out_valid && o_out.request_pending;
    assign burst_seen = o_out_valid && (o_out.control_burst != bsn_pkg::BURST_NONE);
    assign burst_ok   = (o_out.control_burst == bsn_pkg::BURST_GRANT)
                        && o_out.advert_written && o_out.level_applied;
    assign level_ok   = (o_out.tx_alloc_select == o_out.level) && gain_ok;

    always_comb begin
        case (o_out.level)
            2'd0:    gain_ok = (o_out.gain_db == bsn_pkg::GAIN_DB_L0);
            2'd1:    gain_ok = (o_out.gain_db == bsn_pkg::GAIN_DB_L1);
            2'd2:    gain_ok = (o_out.gain_db == bsn_pkg::GAIN_DB_L2);
            default: gain_ok = 1'b0;
        endcase
    end

    // a stalled result holds
    `BSN_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_out_valid && $stable(o_out))

    // with nothing waiting at the output, an offered request is always taken
    `BSN_ASSERT_NOW(a_in_ready, i_clk, i_rst_n, in_open, o_in_ready)

    // an open request only lives while saturated
    `BSN_ASSERT_NOW(a_ask_sat, i_clk, i_rst_n, ask_open, o_out.is_saturated)

    // a grant burst always rewrites control info and reconfigures the radio
    `BSN_ASSERT_NOW(a_grant, i_clk, i_rst_n, burst_seen, burst_ok)

    // level fields agree with each other
    `BSN_ASSERT_NOW(a_level, i_clk, i_rst_n, o_out_valid, level_ok)

endmodule

bind bandwidth_share_negotiator_unit bsn_checker u_bsn_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out       (o_out)
);

// ----- sim/tb.sv -----
// Self-checking testbench for bandwidth_share_negotiator_unit.
// Uses bsn_pkg for the request types, register indexes and constants; drives
// directed and random ticks; checks every result against a predictor or typed row.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT      = 1_000_000;
    localparam int RAND_PER_SETTING = 107;
    localparam int SOAK_TICKS       = 40;
    localparam int HOLD_CYCLES      = 64;
    localparam int DRAIN_SLACK      = 8;

    // index past the register list; the block must drop writes to it
    localparam logic [bsn_pkg::CFG_INDEX_W-1:0] CFG_UNUSED = 2'd3;

    localparam bsn_pkg::t_out_req SHARE_AFTER_RESET = '{
        level: bsn_pkg::LEVEL_RST, advertised_level: bsn_pkg::LEVEL_RST,
        advert_written: 1'b0, control_burst: bsn_pkg::BURST_NONE, level_applied: 1'b0,
        tx_alloc_select: bsn_pkg::LEVEL_RST, rx_alloc_select: bsn_pkg::LEVEL_RST,
        gain_db: bsn_pkg::GAIN_DB_L1, is_saturated: 1'b0, request_pending: 1'b0};
    localparam bsn_pkg::t_out_req SHARE_AT_FLOOR = '{
        level: 2'd0, advertised_level: 2'd0, advert_written: 1'b0,
        control_burst: bsn_pkg::BURST_NONE, level_applied: 1'b0, tx_alloc_select: 2'd0,
        rx_alloc_select: bsn_pkg::LEVEL_MAX, gain_db: bsn_pkg::GAIN_DB_L0,
        is_saturated: 1'b0, request_pending: 1'b0};

    typedef struct packed {
        bsn_pkg::t_in_req  tick;
        logic              typed;  // want holds a hand-written expectation
        bsn_pkg::t_out_req want;
    } t_directed_row;

    // Walk from reset through the hysteresis edges, request, adoption, grants
    // and the refused cases. Level ends at 1, unsaturated, nothing pending.
    t_directed_row directed_rows [16] = '{
        '{'{24'd0,       16'd0,      1'b0, 1'b0, 1'b0, 2'd0}, 1'b1, SHARE_AFTER_RESET},
        // depth equal to the upper bound does not saturate
        '{'{24'd4096,    16'd1000,   1'b0, 1'b0, 1'b0, 2'd0}, 1'b0, '0},
        // saturates, settle count equals limit: no request yet
        '{'{24'd4097,    16'd0,      1'b0, 1'b0, 1'b0, 2'd0}, 1'b0, '0},
        // depth equal to lower bound keeps saturation; count passes limit
        '{'{24'd1024,    16'd1,      1'b0, 1'b0, 1'b0, 2'd0}, 1'b0, '0},
        // adoption on a control frame whose control info is invalid
        '{'{24'd2000,    16'd0,      1'b1, 1'b0, 1'b1, 2'd3}, 1'b0, '0},
        // grant at level two while saturated, depth and tick count at maximum
        '{'{24'hFFFFFF,  16'hFFFF,   1'b1, 1'b1, 1'b1, 2'd1}, 1'b0, '0},
        '{'{24'd3000,    16'd0,      1'b1, 1'b1, 1'b1, 2'd1}, 1'b0, '0},
        // saturation clears, request withdrawn
        '{'{24'd1023,    16'd5,      1'b0, 1'b0, 1'b0, 2'd0}, 1'b0, '0},
        // unsaturated grant down to level zero
        '{'{24'd0,       16'd0,      1'b1, 1'b1, 1'b0, 2'd2}, 1'b0, '0},
        // grant at level zero is ignored
        '{'{24'd0,       16'd0,      1'b1, 1'b1, 1'b1, 2'd3}, 1'b1, SHARE_AT_FLOOR},
        // control info without a frame is not stored
        '{'{24'd0,       16'd0,      1'b0, 1'b1, 1'b0, 2'd2}, 1'b0, '0},
        '{'{24'hFFFFFF,  16'hFFFF,   1'b0, 1'b0, 1'b0, 2'd0}, 1'b0, '0},
        '{'{24'hFFFFFF,  16'd0,      1'b1, 1'b1, 1'b1, 2'd1}, 1'b0, '0},
        // saturated below level two refuses the peer
        '{'{24'hFFFFFF,  16'd0,      1'b1, 1'b1, 1'b0, 2'd2}, 1'b0, '0},
        '{'{24'd5000,    16'd0,      1'b0, 1'b0, 1'b1, 2'd0}, 1'b0, '0},
        '{'{24'd0,       16'd0,      1'b0, 1'b0, 1'b0, 2'd0}, 1'b0, '0}
    };

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            tick_valid = 1'b0;
    logic                            tick_ready;
    bsn_pkg::t_in_req                tick_req = '0;
    logic                            share_valid;
    logic                            share_ready = 1'b0;
    bsn_pkg::t_out_req               share_out;
    logic                            cfg_we = 1'b0;
    logic [bsn_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
    logic [bsn_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

    // predictor copy of the registers and negotiation state
    logic [23:0] sat_upper = bsn_pkg::SAT_UPPER_RST;
    logic [23:0] sat_lower = bsn_pkg::SAT_LOWER_RST;
    logic [31:0] settle_lim = bsn_pkg::SETTLE_LIMIT_RST;
    logic        m_saturated = 1'b0;
    logic        m_asking = 1'b0;
    logic [1:0]  m_own = bsn_pkg::LEVEL_RST;
    logic [1:0]  m_asked = bsn_pkg::LEVEL_RST;
    logic [1:0]  m_peer = 2'd0;
    logic [31:0] m_settle = '0;

    bsn_pkg::t_out_req expected_shares [$];

    int mismatches = 0;
    int ticks_sent = 0;
    int shares_seen = 0;
    int grants_seen = 0;
    int applies_seen = 0;
    int adverts_seen = 0;
    int input_stalls = 0;
    int cycle_count = 0;
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;
    int hold_asked = 0;
    int hold_served = 0;
    int hold_left = 0;

    bandwidth_share_negotiator_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (tick_valid),
        .o_in_ready  (tick_ready),
        .i_in        (tick_req),
        .o_out_valid (share_valid),
        .i_out_ready (share_ready),
        .o_out       (share_out),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    // One engine tick of the negotiation: counter, hysteresis, own request,
    // withdrawal, peer grant, adoption, in that order.
    function automatic bsn_pkg::t_out_req negotiate_tick(input bsn_pkg::t_in_req t);
        bsn_pkg::t_out_req r;
        logic [32:0] sum;
        logic        wrote;
        logic        applied;
        logic [1:0]  burst;
        wrote = 1'b0;
        applied = 1'b0;
        burst = bsn_pkg::BURST_NONE;

        sum = {1'b0, m_settle} + 33'(t.ticks_passed);
        m_settle = sum[32] ? 32'hFFFF_FFFF : sum[31:0];

        if (!m_saturated && t.queue_depth > sat_upper)
            m_saturated = 1'b1;
        else if (m_saturated && t.queue_depth < sat_lower)
            m_saturated = 1'b0;

        if (m_saturated && m_own < bsn_pkg::LEVEL_MAX && !m_asking
                && m_settle > settle_lim) begin
            m_asking = 1'b1;
            m_asked = m_own + 2'd1;
            m_settle = '0;
            wrote = 1'b1;
        end

        if (!m_saturated && m_asking) begin
            m_asking = 1'b0;
            m_asked = m_own;
            wrote = 1'b1;
        end

        if (t.frame_received && t.control_ok) begin
            m_peer = t.peer_request;
            if (3'(m_peer) + 3'(m_own) > 3'(bsn_pkg::LEVEL_MAX) && m_own != 2'd0 &&
                (!m_saturated || m_own == bsn_pkg::LEVEL_MAX)) begin
                m_own = m_own - 2'd1;
                if (m_asked != 2'd0)
                    m_asked = m_asked - 2'd1;
                wrote = 1'b1;
                burst = bsn_pkg::BURST_GRANT;
                applied = 1'b1;
            end
        end

        if (t.frame_is_control && m_asking
                && 3'(m_peer) + 3'(m_asked) == 3'(bsn_pkg::LEVEL_MAX)) begin
            m_asking = 1'b0;
            m_own = m_asked;
            applied = 1'b1;
        end

        r.level = m_own;
        r.advertised_level = m_asked;
        r.advert_written = wrote;
        r.control_burst = burst;
        r.level_applied = applied;
        r.tx_alloc_select = m_own;
        r.rx_alloc_select = bsn_pkg::LEVEL_MAX - m_own;
        case (m_own)
            2'd0: r.gain_db = bsn_pkg::GAIN_DB_L0;
            2'd1: r.gain_db = bsn_pkg::GAIN_DB_L1;
            default: r.gain_db = bsn_pkg::GAIN_DB_L2;
        endcase
        r.is_saturated = m_saturated;
        r.request_pending = m_asking;
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("mismatch at result %0d: %s got %0h expected %0h",
                 shares_seen, what, got, want);
        mismatches++;
    endtask

    task automatic check_field(input string what, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want)
            flag_mismatch(what, got, want);
    endtask

    // Result side: compare against the oldest expectation at each accept.
    always @(posedge clk) begin : share_check
        bsn_pkg::t_out_req want;
        if (rst_n && tick_valid && !tick_ready)
            input_stalls++;
        if (rst_n && share_valid && share_ready) begin
            if (expected_shares.size() == 0) begin
                flag_mismatch("result with nothing outstanding", 32'(share_out), '0);
            end else begin
                want = expected_shares.pop_front();
                check_field("level", 32'(share_out.level), 32'(want.level));
                check_field("advertised_level", 32'(share_out.advertised_level),
                            32'(want.advertised_level));
                check_field("advert_written", 32'(share_out.advert_written),
                            32'(want.advert_written));
                check_field("control_burst", 32'(share_out.control_burst),
                            32'(want.control_burst));
                check_field("level_applied", 32'(share_out.level_applied),
                            32'(want.level_applied));
                check_field("tx_alloc_select", 32'(share_out.tx_alloc_select),
                            32'(want.tx_alloc_select));
                check_field("rx_alloc_select", 32'(share_out.rx_alloc_select),
                            32'(want.rx_alloc_select));
                check_field("gain_db", 32'(share_out.gain_db), 32'(want.gain_db));
                check_field("is_saturated", 32'(share_out.is_saturated),
                            32'(want.is_saturated));
                check_field("request_pending", 32'(share_out.request_pending),
                            32'(want.request_pending));
            end
            shares_seen++;
            if (share_out.control_burst == bsn_pkg::BURST_GRANT)
                grants_seen++;
            if (share_out.level_applied)
                applies_seen++;
            if (share_out.advert_written)
                adverts_seen++;
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is asked for,
    // so the block backs up and drops its input ready.
    always @(negedge clk) begin
        if (hold_left != 0) begin
            share_ready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_asked) begin
            share_ready <= 1'b0;
            hold_left <= HOLD_CYCLES - 1;
            hold_served <= hold_served + 1;
        end else begin
            share_ready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, expected_shares.size());
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // All driving tasks start and end on a falling edge.
    task automatic push_tick(input bsn_pkg::t_in_req t, input bit typed,
                             input bsn_pkg::t_out_req want);
        bsn_pkg::t_out_req predicted;
        tick_valid <= 1'b1;
        tick_req <= t;
        @(posedge clk);
        while (!tick_ready)
            @(posedge clk);
        predicted = negotiate_tick(t);
        expected_shares.push_back(typed ? want : predicted);
        ticks_sent++;
        @(negedge clk);
    endtask

    task automatic idle_gap(input int pct);
        while ($urandom_range(99) < pct) begin
            tick_valid <= 1'b0;
            @(negedge clk);
        end
    endtask

    task automatic drain_requests();
        tick_valid <= 1'b0;
        @(negedge clk);
        while (expected_shares.size() != 0)
            @(negedge clk);
    endtask

    task automatic write_reg(input logic [bsn_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [bsn_pkg::CFG_DATA_W-1:0] data);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        case (idx)
            bsn_pkg::CFG_SAT_UPPER:    sat_upper = data[23:0];
            bsn_pkg::CFG_SAT_LOWER:    sat_lower = data[23:0];
            bsn_pkg::CFG_SETTLE_LIMIT: settle_lim = data;
            default: ;
        endcase
        @(negedge clk);
    endtask

    // Only called with the block drained. Data bits above the 24-bit registers
    // carry noise, and a stray write to the unused index follows.
    task automatic apply_setting(input logic [23:0] upper, input logic [23:0] lower,
                                 input logic [31:0] limit);
        write_reg(bsn_pkg::CFG_SAT_UPPER, {8'($urandom), upper});
        write_reg(bsn_pkg::CFG_SAT_LOWER, {8'($urandom), lower});
        write_reg(bsn_pkg::CFG_SETTLE_LIMIT, limit);
        write_reg(CFG_UNUSED, $urandom);
        cfg_we <= 1'b0;
    endtask

    // Depths cluster on the hysteresis bounds so saturation toggles often.
    function automatic logic [23:0] pick_depth();
        case ($urandom_range(9))
            0: return 24'd0;
            1: return 24'hFFFFFF;
            2: return (sat_upper == 24'hFFFFFF) ? sat_upper : sat_upper + 24'd1;
            3: return (sat_lower == 24'd0) ? 24'd0 : sat_lower - 24'd1;
            4: return sat_upper;
            5: return sat_lower;
            6, 7: begin
                if (sat_upper == 24'hFFFFFF)
                    return sat_upper;
                return 24'($urandom_range(32'hFFFFFF, 32'(sat_upper) + 1));
            end
            8: return 24'($urandom_range(32'(sat_lower), 0));
            default: return 24'($urandom);
        endcase
    endfunction

    // Mostly plausible traffic: peer values that match the pending ask or
    // that push a grant, with some arbitrary noise.
    function automatic bsn_pkg::t_in_req random_tick();
        bsn_pkg::t_in_req t;
        t.queue_depth = pick_depth();
        case ($urandom_range(9))
            0, 1: t.ticks_passed = 16'd0;
            2: t.ticks_passed = 16'hFFFF;
            default: t.ticks_passed = 16'($urandom_range(1500));
        endcase
        t.frame_received = ($urandom_range(99) < 60);
        t.control_ok = ($urandom_range(99) < 75);
        t.frame_is_control = ($urandom_range(99) < 50);
        case ($urandom_range(9))
            0, 1, 2, 3: t.peer_request = bsn_pkg::LEVEL_MAX - m_asked;
            4, 5, 6: t.peer_request = 2'd3 - m_own;
            default: t.peer_request = 2'($urandom);
        endcase
        return t;
    endfunction

    initial begin
        int               ph;
        int               n;
        logic [23:0]      up;
        logic [23:0]      lo;
        logic [31:0]      lim;
        bsn_pkg::t_in_req flood;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed walk on the reset register values
        tx_idle_pct = 21;
        rx_stall_pct = 84;
        foreach (directed_rows[i]) begin
            idle_gap(tx_idle_pct);
            push_tick(directed_rows[i].tick, directed_rows[i].typed, directed_rows[i].want);
        end

        // Settle limit at maximum: keep the link saturated with large tick
        // counts; no request may fire. One below the maximum still needs a
        // clamped counter, so the next saturated tick stays quiet as well.
        drain_requests();
        apply_setting(bsn_pkg::SAT_UPPER_RST, bsn_pkg::SAT_LOWER_RST, 32'hFFFF_FFFF);
        flood = '{24'hFFFFFF, 16'hFFFF, 1'b0, 1'b0, 1'b0, 2'd0};
        for (n = 0; n < SOAK_TICKS; n++)
            push_tick(flood, 1'b0, '0);
        drain_requests();
        apply_setting(bsn_pkg::SAT_UPPER_RST, bsn_pkg::SAT_LOWER_RST, 32'hFFFF_FFFE);
        push_tick('{24'hFFFFFF, 16'd0, 1'b0, 1'b0, 1'b0, 2'd0}, 1'b0, '0);
        push_tick('{24'd0, 16'd0, 1'b0, 1'b0, 1'b0, 2'd0}, 1'b0, '0);

        // random part: two register settings per idling pattern
        for (ph = 0; ph < 6; ph++) begin
            drain_requests();
            case (ph / 2)
                0: begin
                    tx_idle_pct = 21;
                    rx_stall_pct = 84;
                end
                1: begin
                    tx_idle_pct = 84;
                    rx_stall_pct = 21;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_stall_pct = 0;
                end
            endcase
            up = 24'($urandom_range(200000, 64));
            lo = 24'($urandom_range(32'(up), 0));
            lim = 32'($urandom_range(5000));
            case (ph)
                0: apply_setting(bsn_pkg::SAT_UPPER_RST, bsn_pkg::SAT_LOWER_RST,
                                 bsn_pkg::SETTLE_LIMIT_RST);
                1: apply_setting(24'd0, 24'd0, 32'd0);          // saturation sticks
                3: apply_setting(24'hFFFFFF, 24'hFFFFFF, 32'd0);
                4: apply_setting(24'd100, 24'd50000, lim);      // inverted bounds
                default: apply_setting(up, lo, lim);
            endcase
            hold_asked++;
            for (n = 0; n < RAND_PER_SETTING; n++) begin
                // midway, stop sending until every result is back
                if (n == RAND_PER_SETTING / 2)
                    drain_requests();
                idle_gap(tx_idle_pct);
                push_tick(random_tick(), 1'b0, '0);
            end
        end

        drain_requests();
        repeat (DRAIN_SLACK) @(negedge clk);

        $display("run covered %0d tick requests and %0d results, incl. a %0d-tick flood",
                 ticks_sent, shares_seen, SOAK_TICKS);
        $display("seen: %0d grants, %0d level changes, %0d advert writes, %0d input stalls",
                 grants_seen, applies_seen, adverts_seen, input_stalls);
        if (mismatches == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
